// ===== sv/ttc_pkg.sv =====
package ttc_pkg;

  // default geometry of the text store
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // configuration register indexes
  localparam logic CFG_CURSOR_VISIBLE = 1'b0;
  localparam logic CFG_UTF8_ENABLE    = 1'b1;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BLANK   = 8'h00;

  // utf-8 lead bytes and pending lead codes
  localparam logic [7:0] UTF8_LEAD_D0 = 8'hD0;
  localparam logic [7:0] UTF8_LEAD_D1 = 8'hD1;
  localparam logic [1:0] LEAD_NONE    = 2'd0;
  localparam logic [1:0] LEAD_D0      = 2'd1;
  localparam logic [1:0] LEAD_D1      = 2'd2;

  typedef enum logic [2:0] {
    OP_PUT        = 3'd0,
    OP_SET_CURSOR = 3'd1,
    OP_SET_COLOUR = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_SCROLL_LAST,
    S_CLEAR,
    S_DONE
  } state_e;

  // fold the second byte of a two-byte cyrillic sequence into the code page
  function automatic logic [7:0] fold_cyrillic(input logic [1:0] lead, input logic [7:0] b);
    logic [7:0] r;
    if (lead == LEAD_D0) begin
      r = (b == 8'h81) ? 8'hF0 : b - 8'h10;
    end else if (b == 8'h91) begin
      r = 8'hF1;
    end else if (b < 8'hB0) begin
      r = b + 8'h60;
    end else begin
      r = b + 8'h10;
    end
    return r;
  endfunction

endpackage

// ===== sv/teletype_text_console.sv =====
// Teletype console over a COLUMNS x ROWS store of character/attribute cells held in
// one single-port-write, registered-read memory. A put, set cursor, set colour or
// unused op goes from accept straight to S_DONE, where its result is loaded into the
// output register; a cell read passes through S_READ first for the memory read. A put
// that runs past the last row scrolls: an address counter walks every cell once,
// copying row r+1 to row r through the registered read and then filling the bottom
// row with spaces. A clear writes one cell per cycle. The store holds no defined
// contents until the first clear. Input stall is high from accept until the result
// has been loaded into the output register.
module teletype_text_console
  import ttc_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] op_i,
  input  logic [7:0] data_i,
  input  logic [6:0] pos_x_i,
  input  logic [4:0] pos_y_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_shown_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attr_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = ($clog2(ROWS) > 5) ? $clog2(ROWS) : 5;

  localparam logic [AW-1:0] CNT_LAST   = AW'(CELLS - 1);
  localparam logic [AW-1:0] FILL_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
  localparam logic [7:0]    COLS_X     = 8'(COLUMNS);
  localparam logic [RW:0]   ROWS_X     = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
  localparam logic [4:0]    ROW_HIDDEN = 5'(ROWS);

  state_e state_q, state_d;

  logic [6:0]    col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [7:0]    colour_q, colour_d;
  logic [1:0]    lead_q, lead_d;
  logic          cursor_vis_q;
  logic          utf8_en_q;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          pend_fill_q, pend_fill_d;
  logic          rd_ok_q, rd_ok_d;
  logic [7:0]    cell_char_q, cell_char_d;
  logic [7:0]    cell_attr_q, cell_attr_d;
  logic          out_valid_q;
  logic [6:0]    out_col_q;
  logic [4:0]    out_row_q;
  logic [7:0]    out_char_q;
  logic [7:0]    out_attr_q;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [15:0]   st_wdata;
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic [15:0]   st_rdata;

  logic          in_acc;
  logic          out_free;
  logic          out_load;

  // teletype step for a put
  logic [7:0]    put_byte;
  logic          put_lead_only;
  logic [7:0]    col_inc;
  logic [RW:0]   row_inc;
  logic          put_we;
  logic [AW-1:0] put_addr;
  logic [6:0]    tty_col;
  logic [RW-1:0] tty_row;
  logic          tty_scroll;
  logic          rd_in_range;
  logic [AW-1:0] rd_addr;
  logic          fill_now;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_DONE) && out_free;
  assign fill_now = cnt_q >= FILL_START;

  // cell store
  ttc_store #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // byte decode, cursor advance, wrap and scroll decision
  always_comb begin
    put_byte      = (utf8_en_q && lead_q != LEAD_NONE) ? fold_cyrillic(lead_q, data_i)
                                                        : data_i;
    put_lead_only = utf8_en_q && (lead_q == LEAD_NONE) &&
                    (data_i == UTF8_LEAD_D0 || data_i == UTF8_LEAD_D1);
    col_inc       = (put_byte == CH_NEWLINE) ? COLS_X : {1'b0, col_q} + 8'd1;
    put_we        = (put_byte != CH_NEWLINE) && ({1'b0, col_q} < COLS_X) &&
                    ({1'b0, row_q} < ROWS_X);
    put_addr      = AW'(row_q) * COLS_A + AW'(col_q);
    if (col_inc >= COLS_X) begin
      tty_col = 7'd0;
      row_inc = {1'b0, row_q} + (RW + 1)'(1);
    end else begin
      tty_col = col_inc[6:0];
      row_inc = {1'b0, row_q};
    end
    tty_scroll  = row_inc >= ROWS_X;
    tty_row     = tty_scroll ? ROW_LAST : row_inc[RW-1:0];
    rd_in_range = ({1'b0, pos_x_i} < COLS_X) && ((RW + 1)'(pos_y_i) < ROWS_X);
    rd_addr     = AW'(pos_y_i) * COLS_A + AW'(pos_x_i);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(op_i))
            OP_PUT:   state_d = (!put_lead_only && tty_scroll) ? S_SCROLL : S_DONE;
            OP_CLEAR: state_d = S_CLEAR;
            OP_READ:  state_d = S_READ;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_READ:        state_d = S_DONE;
      S_SCROLL:      state_d = (cnt_q == CNT_LAST) ? S_SCROLL_LAST : S_SCROLL;
      S_SCROLL_LAST: state_d = S_DONE;
      S_CLEAR:       state_d = (cnt_q == CNT_LAST) ? S_DONE : S_CLEAR;
      S_DONE:        state_d = out_free ? S_IDLE : S_DONE;
      default:       state_d = S_IDLE;
    endcase
  end

  // datapath and store controls per state
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    colour_d    = colour_q;
    lead_d      = lead_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pend_fill_d = pend_fill_q;
    rd_ok_d     = rd_ok_q;
    cell_char_d = cell_char_q;
    cell_attr_d = cell_attr_q;
    st_we       = 1'b0;
    st_waddr    = put_addr;
    st_wdata    = {colour_q, put_byte};
    st_re       = 1'b0;
    st_raddr    = rd_addr;
    in_stall_o  = state_q != S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cell_char_d = CH_BLANK;
          cell_attr_d = 8'h00;
          cnt_d       = '0;
          pend_d      = 1'b0;
          case (op_e'(op_i))
            OP_PUT: begin
              if (put_lead_only) begin
                lead_d = (data_i == UTF8_LEAD_D0) ? LEAD_D0 : LEAD_D1;
              end else begin
                lead_d = LEAD_NONE;
                col_d  = tty_col;
                row_d  = tty_row;
                st_we  = put_we;
              end
            end
            OP_SET_CURSOR: begin
              col_d = pos_x_i;
              row_d = RW'(pos_y_i);
            end
            OP_SET_COLOUR: colour_d = data_i;
            OP_CLEAR: begin
              colour_d = data_i;
              col_d    = 7'd0;
              row_d    = '0;
            end
            OP_READ: begin
              st_re   = rd_in_range;
              rd_ok_d = rd_in_range;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cell_char_d = rd_ok_q ? st_rdata[7:0] : CH_BLANK;
        cell_attr_d = rd_ok_q ? st_rdata[15:8] : 8'h00;
      end
      S_SCROLL: begin
        // read one row ahead, write the previous cycle's cell
        st_we       = pend_q;
        st_waddr    = pend_addr_q;
        st_wdata    = pend_fill_q ? {colour_q, CH_SPACE} : st_rdata;
        st_re       = !fill_now;
        st_raddr    = cnt_q + COLS_A;
        pend_d      = 1'b1;
        pend_addr_d = cnt_q;
        pend_fill_d = fill_now;
        cnt_d       = cnt_q + AW'(1);
      end
      S_SCROLL_LAST: begin
        st_we    = pend_q;
        st_waddr = pend_addr_q;
        st_wdata = pend_fill_q ? {colour_q, CH_SPACE} : st_rdata;
        pend_d   = 1'b0;
      end
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = cnt_q;
        st_wdata = {colour_q, CH_BLANK};
        cnt_d    = cnt_q + AW'(1);
      end
      S_DONE: ;
      default: ;
    endcase
    // a write of the utf-8 enable drops any pending lead byte
    if (cfg_we_i && cfg_idx_i == CFG_UTF8_ENABLE) begin
      lead_d = LEAD_NONE;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      col_q        <= 7'd0;
      row_q        <= '0;
      colour_q     <= 8'h00;
      lead_q       <= LEAD_NONE;
      cursor_vis_q <= 1'b1;
      utf8_en_q    <= 1'b0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      colour_q <= colour_d;
      lead_q   <= lead_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      if (cfg_we_i && cfg_idx_i == CFG_CURSOR_VISIBLE) begin
        cursor_vis_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_UTF8_ENABLE) begin
        utf8_en_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_fill_q <= pend_fill_d;
    rd_ok_q     <= rd_ok_d;
    cell_char_q <= cell_char_d;
    cell_attr_q <= cell_attr_d;
    if (out_load) begin
      out_col_q  <= col_q;
      out_row_q  <= cursor_vis_q ? row_q[4:0] : ROW_HIDDEN;
      out_char_q <= cell_char_q;
      out_attr_q <= cell_attr_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign cursor_col_o       = out_col_q;
  assign cursor_row_shown_o = out_row_q;
  assign cell_char_o        = out_char_q;
  assign cell_attr_o        = out_attr_q;

  // store writes stay inside the array
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (int'(st_waddr) < CELLS))
    else $error("store write beyond last cell");

  // an accepted word holds off the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken again right after accept");

  // after a scroll the cursor sits on the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL_LAST) |-> (row_q == ROW_LAST))
    else $error("cursor not on last row after scroll");

  // a pending copy write exists only inside the scroll walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCROLL || state_q == S_SCROLL_LAST))
    else $error("scroll write pending outside scroll");

  // a result is loaded only when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q == S_DONE) |=> (state_q == S_DONE))
    else $error("result dropped while output stalled");

endmodule

// ===== sv/ttc_store.sv =====
module ttc_store
  import ttc_pkg::*;
#(
  parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
